// ----- design/pidt_pkg.sv -----
package pidt_pkg;

  localparam int unsigned ANGLE_W    = 16;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned LIMIT_W    = 15;
  localparam int unsigned IDX_W      = 10;
  localparam int unsigned TIDX_W     = 11;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // PID datapath widths
  localparam int unsigned ERR_W   = ANGLE_W + 1;
  localparam int unsigned DER_W   = ANGLE_W + 2;
  localparam int unsigned INTEG_W = 32;
  localparam int unsigned PP_W    = GAIN_W + ERR_W;
  localparam int unsigned PI_W    = GAIN_W + INTEG_W;
  localparam int unsigned PD_W    = GAIN_W + DER_W;
  localparam int unsigned SUM_W   = PI_W + 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_PROP     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_INTEG    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_DERIV    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CURRENT_LIMIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TARGET   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TRACK_LAST    = 3'd5;

  typedef enum logic [1:0] {
    ACT_TICK      = 2'd0,
    ACT_WRITE_REF = 2'd1,
    ACT_SET_MODE  = 2'd2,
    ACT_READ      = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_HOLD  = 2'd1,
    MODE_TRACK = 2'd2
  } mode_e;

  // side information that travels with a word down the PID pipeline
  typedef struct packed {
    logic                       pid;
    mode_e                      mode;
    logic                       done;
    logic signed [ANGLE_W-1:0]  rd_meas;
    logic signed [ANGLE_W-1:0]  rd_ref;
  } pidt_info_t;

endpackage

// ----- design/pidt_in_if.sv -----
interface pidt_in_if import pidt_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [1:0]                action;
  logic signed [ANGLE_W-1:0] measured_angle;
  logic [IDX_W-1:0]          entry_index;
  logic signed [ANGLE_W-1:0] entry_value;
  logic [1:0]                new_mode;

  modport source (
    output valid, action, measured_angle, entry_index, entry_value, new_mode,
    input  ready
  );

  modport sink (
    input  valid, action, measured_angle, entry_index, entry_value, new_mode,
    output ready
  );
endinterface

// ----- design/pidt_out_if.sv -----
interface pidt_out_if import pidt_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [ANGLE_W-1:0] command;
  logic                      command_valid;
  logic [1:0]                mode_now;
  logic                      track_done;
  logic signed [ANGLE_W-1:0] read_measured;
  logic signed [ANGLE_W-1:0] read_reference;

  modport source (
    output valid, command, command_valid, mode_now, track_done, read_measured,
           read_reference,
    input  ready
  );

  modport sink (
    input  valid, command, command_valid, mode_now, track_done, read_measured,
           read_reference,
    output ready
  );
endinterface

// ----- design/pidt_ram.sv -----
module pidt_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ----- design/pid_position_loop_with_track_top.sv -----
// Position PID loop with a stored reference trajectory. One word is accepted per
// clock unless the output stalls; a synchronous read of the trajectory memories,
// the error and integral update, the three gain products, their sum, and the
// rounding and current clamp each take one pipeline stage. The integral and
// previous error are updated in a single stage, so words stream back to back
// with no interlock; memory writes happen at acceptance, ahead of any later read.
// A full output register that is not taken stalls the whole pipeline and drops
// ready. Gains are signed Q8.8 (GAIN_FRAC_BITS fraction bits); the memories are
// not cleared, so read only entries already written.
module pid_position_loop_with_track_top import pidt_pkg::*; #(
  parameter int unsigned TRAJ_DEPTH     = 1024,
  parameter int unsigned GAIN_FRAC_BITS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  pidt_in_if.sink               in_i,
  pidt_out_if.source            out_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned AW = $clog2(TRAJ_DEPTH);
  localparam logic signed [SUM_W-1:0] RND_BIAS =
    SUM_W'((64'd1 << GAIN_FRAC_BITS) - 64'd1);

  // configuration
  logic signed [GAIN_W-1:0]  gain_prop_q, gain_integ_q, gain_deriv_q;
  logic [LIMIT_W-1:0]        limit_q;
  logic signed [ANGLE_W-1:0] hold_target_q;
  logic [IDX_W-1:0]          track_last_q;

  // loop state
  mode_e                     mode_q, mode_d;
  logic [TIDX_W-1:0]         tidx_q, tidx_d;
  logic signed [INTEG_W-1:0] integ_q;
  logic signed [ERR_W-1:0]   prev_err_q;

  logic en, accept;

  // stage 0 decode
  logic             pid_s0, use_ref_s0, done_s0, rd_ok_s0;
  logic             ref_we, meas_we;
  logic [31:0]      idx_ext, tidx_ext;
  logic [AW-1:0]    idx_addr, tidx_addr, ref_raddr;
  logic             idx_in_range, tidx_end;

  logic [ANGLE_W-1:0] ref_rdata, meas_rdata;

  // stage A
  logic                      a_valid_q;
  logic                      a_pid_q, a_use_ref_q, a_done_q, a_rd_ok_q;
  mode_e                     a_mode_q;
  logic signed [ANGLE_W-1:0] a_meas_q;

  // stage B
  logic signed [ANGLE_W-1:0] target_w;
  logic signed [ERR_W-1:0]   err_w;
  logic signed [INTEG_W:0]   integ_sum_w;
  logic signed [INTEG_W-1:0] integ_d;
  logic signed [DER_W-1:0]   deriv_w;
  logic                      b_valid_q;
  pidt_info_t                b_info_q;
  logic signed [ERR_W-1:0]   b_err_q;
  logic signed [INTEG_W-1:0] b_integ_q;
  logic signed [DER_W-1:0]   b_deriv_q;

  // stage C
  logic                      c_valid_q;
  pidt_info_t                c_info_q;
  logic signed [PP_W-1:0]    c_pp_q;
  logic signed [PI_W-1:0]    c_pi_q;
  logic signed [PD_W-1:0]    c_pd_q;

  // stage D
  logic                      d_valid_q;
  pidt_info_t                d_info_q;
  logic signed [SUM_W-1:0]   d_u_q;

  // output
  logic signed [SUM_W-1:0]   q_w, lim_w, clamp_w, bias_w;
  logic signed [ANGLE_W-1:0] cmd_d;
  logic                      out_valid_q;
  pidt_info_t                out_info_q;
  logic signed [ANGLE_W-1:0] out_cmd_q;

  assign en          = !out_valid_q || out_o.ready;
  assign in_i.ready  = en;
  assign accept      = in_i.valid && en;

  // ---------------------------------------------------------------------------
  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_prop_q   <= '0;
      gain_integ_q  <= '0;
      gain_deriv_q  <= '0;
      limit_q       <= '0;
      hold_target_q <= '0;
      track_last_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_GAIN_PROP:     gain_prop_q   <= signed'(cfg_data_i[GAIN_W-1:0]);
        CFG_GAIN_INTEG:    gain_integ_q  <= signed'(cfg_data_i[GAIN_W-1:0]);
        CFG_GAIN_DERIV:    gain_deriv_q  <= signed'(cfg_data_i[GAIN_W-1:0]);
        CFG_CURRENT_LIMIT: limit_q       <= cfg_data_i[LIMIT_W-1:0];
        CFG_HOLD_TARGET:   hold_target_q <= signed'(cfg_data_i[ANGLE_W-1:0]);
        CFG_TRACK_LAST:    track_last_q  <= cfg_data_i[IDX_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // stage 0: decode the word, update mode and track index, issue memory access
  assign idx_ext      = 32'(in_i.entry_index);
  assign tidx_ext     = 32'(tidx_q);
  assign idx_addr     = idx_ext[AW-1:0];
  assign tidx_addr    = tidx_ext[AW-1:0];
  assign idx_in_range = idx_ext < 32'(TRAJ_DEPTH);
  assign tidx_end     = (tidx_q > TIDX_W'(track_last_q)) || (tidx_ext >= 32'(TRAJ_DEPTH));

  always_comb begin
    mode_d     = mode_q;
    tidx_d     = tidx_q;
    pid_s0     = 1'b0;
    use_ref_s0 = 1'b0;
    done_s0    = 1'b0;
    rd_ok_s0   = 1'b0;
    ref_we     = 1'b0;
    meas_we    = 1'b0;
    case (action_e'(in_i.action))
      ACT_TICK: begin
        if (mode_q == MODE_HOLD) begin
          pid_s0 = 1'b1;
        end else if (mode_q == MODE_TRACK) begin
          if (tidx_end) begin
            // trajectory finished: rewind and fall back to hold
            tidx_d  = '0;
            mode_d  = MODE_HOLD;
            done_s0 = 1'b1;
          end else begin
            pid_s0     = 1'b1;
            use_ref_s0 = 1'b1;
            meas_we    = accept;
            tidx_d     = tidx_q + 1'b1;
          end
        end
      end
      ACT_WRITE_REF: begin
        ref_we = accept && idx_in_range;
      end
      ACT_SET_MODE: begin
        if (in_i.new_mode inside {MODE_IDLE, MODE_HOLD, MODE_TRACK}) begin
          mode_d = mode_e'(in_i.new_mode);
        end
      end
      ACT_READ: begin
        rd_ok_s0 = idx_in_range;
      end
      default: ;
    endcase
  end

  assign ref_raddr = use_ref_s0 ? tidx_addr : idx_addr;

  pidt_ram #(
    .WIDTH (ANGLE_W),
    .DEPTH (TRAJ_DEPTH)
  ) u_ref_ram (
    .clk_i   (clk_i),
    .we_i    (ref_we),
    .waddr_i (idx_addr),
    .wdata_i (in_i.entry_value),
    .re_i    (en),
    .raddr_i (ref_raddr),
    .rdata_o (ref_rdata)
  );

  pidt_ram #(
    .WIDTH (ANGLE_W),
    .DEPTH (TRAJ_DEPTH)
  ) u_meas_ram (
    .clk_i   (clk_i),
    .we_i    (meas_we),
    .waddr_i (tidx_addr),
    .wdata_i (in_i.measured_angle),
    .re_i    (en),
    .raddr_i (idx_addr),
    .rdata_o (meas_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_IDLE;
      tidx_q    <= '0;
      a_valid_q <= 1'b0;
    end else if (en) begin
      a_valid_q <= in_i.valid;
      if (in_i.valid) begin
        mode_q <= mode_d;
        tidx_q <= tidx_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_pid_q     <= pid_s0;
      a_use_ref_q <= use_ref_s0;
      a_done_q    <= done_s0;
      a_rd_ok_q   <= rd_ok_s0;
      a_mode_q    <= mode_d;
      a_meas_q    <= in_i.measured_angle;
    end
  end

  // ---------------------------------------------------------------------------
  // stage B: error, saturating integral, derivative
  assign target_w    = a_use_ref_q ? signed'(ref_rdata) : hold_target_q;
  assign err_w       = ERR_W'(target_w) - ERR_W'(a_meas_q);
  assign integ_sum_w = (INTEG_W+1)'(integ_q) + (INTEG_W+1)'(err_w);
  assign deriv_w     = DER_W'(err_w) - DER_W'(prev_err_q);

  always_comb begin
    integ_d = integ_sum_w[INTEG_W-1:0];
    if (integ_sum_w[INTEG_W] != integ_sum_w[INTEG_W-1]) begin
      integ_d = integ_sum_w[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}}
                                     : {1'b0, {(INTEG_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q    <= '0;
      prev_err_q <= '0;
      b_valid_q  <= 1'b0;
    end else if (en) begin
      b_valid_q <= a_valid_q;
      if (a_valid_q && a_pid_q) begin
        integ_q    <= integ_d;
        prev_err_q <= err_w;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b_info_q.pid     <= a_pid_q;
      b_info_q.mode    <= a_mode_q;
      b_info_q.done    <= a_done_q;
      b_info_q.rd_meas <= a_rd_ok_q ? signed'(meas_rdata) : '0;
      b_info_q.rd_ref  <= a_rd_ok_q ? signed'(ref_rdata) : '0;
      b_err_q          <= err_w;
      b_integ_q        <= integ_d;
      b_deriv_q        <= deriv_w;
    end
  end

  // ---------------------------------------------------------------------------
  // stage C: gain products
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
    end else if (en) begin
      c_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_info_q <= b_info_q;
      c_pp_q   <= gain_prop_q * b_err_q;
      c_pi_q   <= gain_integ_q * b_integ_q;
      c_pd_q   <= gain_deriv_q * b_deriv_q;
    end
  end

  // ---------------------------------------------------------------------------
  // stage D: exact sum
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_valid_q <= 1'b0;
    end else if (en) begin
      d_valid_q <= c_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_info_q <= c_info_q;
      d_u_q    <= SUM_W'(c_pp_q) + SUM_W'(c_pi_q) + SUM_W'(c_pd_q);
    end
  end

  // ---------------------------------------------------------------------------
  // output: scale toward zero, clamp to the current limit
  assign bias_w = d_u_q[SUM_W-1] ? RND_BIAS : '0;
  assign q_w    = (d_u_q + bias_w) >>> GAIN_FRAC_BITS;
  assign lim_w  = signed'({{(SUM_W-LIMIT_W){1'b0}}, limit_q});

  always_comb begin
    clamp_w = q_w;
    if (q_w > lim_w) begin
      clamp_w = lim_w;
    end else if (q_w < -lim_w) begin
      clamp_w = -lim_w;
    end
    cmd_d = d_info_q.pid ? clamp_w[ANGLE_W-1:0] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= d_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_info_q <= d_info_q;
      out_cmd_q  <= cmd_d;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.command        = out_cmd_q;
  assign out_o.command_valid  = out_info_q.pid;
  assign out_o.mode_now       = out_info_q.mode;
  assign out_o.track_done     = out_info_q.done;
  assign out_o.read_measured  = out_info_q.rd_meas;
  assign out_o.read_reference = out_info_q.rd_ref;

  // ---------------------------------------------------------------------------
  a_cmd_in_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_info_q.pid |->
      (out_cmd_q <= signed'({1'b0, limit_q})) && (out_cmd_q >= -signed'({1'b0, limit_q})))
    else $error("command outside current limit");

  a_done_to_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_info_q.done |-> out_info_q.mode == MODE_HOLD && !out_info_q.pid)
    else $error("track end word must report hold and no command");

  a_no_cmd_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_info_q.pid |-> out_cmd_q == '0)
    else $error("command nonzero without a PID update");

  a_state_held_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(integ_q) && $stable(prev_err_q) && $stable(tidx_q))
    else $error("loop state moved while stalled");

endmodule
